@@ rtl/tks_pkg.sv @@
// ----------------------------------------------------------------------------
// tks_pkg
// shared types and constants of the trigram key swap scorer
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int unsigned SymW    = 5;
  localparam int unsigned Letters = 26;
  localparam int unsigned IdxW    = 15;
  localparam int unsigned WtW     = 16;
  localparam int unsigned LpW     = 24;
  localparam int unsigned AccW    = 56;
  localparam int unsigned CntW    = 13;
  localparam int unsigned ProdW   = 41;

  // request layout on the slave side tdata
  localparam int unsigned InDataW   = 88;
  localparam int unsigned OffIndex  = 0;
  localparam int unsigned OffFirst  = 15;
  localparam int unsigned OffSecond = 20;
  localparam int unsigned OffThird  = 25;
  localparam int unsigned OffWeight = 30;
  localparam int unsigned OffLogP   = 46;
  localparam int unsigned OffKeyVal = 70;
  localparam int unsigned OffLetA   = 75;
  localparam int unsigned OffLetB   = 80;

  typedef enum logic [2:0] {
    OP_WR_EVENT = 3'd0,
    OP_WR_TABLE = 3'd1,
    OP_WR_KEY   = 3'd2,
    OP_SWAP     = 3'd3,
    OP_SCORE    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_CAP,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [WtW-1:0]  weight;
    logic [SymW-1:0] id_third;
    logic [SymW-1:0] id_second;
    logic [SymW-1:0] id_first;
  } event_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic swap;
  } mac_ctrl_t;

endpackage

@@ rtl/trigram_key_swap_scorer.sv @@
// ----------------------------------------------------------------------------
// trigram_key_swap_scorer
// scores a substitution key against weighted trigram events
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, op in tuser. Event, table and key
// writes give no result. Score and swap queries give one result on m_axis:
// the signed Q.24 sum in tdata, kind and saturation in tuser. For a query,
// one event a cycle is read from the event memory, up to the active event
// count, mapped through three copies of the key memory and looked up on
// the two read ports of the table memory, and the pipeline drains before
// the result is loaded. A swap of a letter with itself, or with a letter
// above 25, scans nothing and returns zero. Only one request is worked on
// at a time; the next one is taken in the cycle the result appears. Writes
// are taken while a result still waits on m_axis, and a query finishes its
// scan and holds in place until the previous result is taken. The user is
// to write event_count through cfg_we_i only while no query is in flight;
// the block itself does not enforce this. Reset clears control state and
// the count; the memories hold nothing defined until written.
// ----------------------------------------------------------------------------
module trigram_key_swap_scorer #(
  parameter int unsigned MAX_EVENTS = 4096,
  parameter int unsigned SYMBOLS    = 27
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tks_pkg::CntW-1:0]      cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // index, id_first, id_second, id_third, event_weight, log_prob, key_value,
  // letter_a, letter_b, zero pad
  input  logic [tks_pkg::InDataW-1:0]   s_axis_tdata_i,
  // op
  input  logic [2:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // result_value
  output logic [tks_pkg::AccW-1:0]      m_axis_tdata_o,
  // result_kind, saturated
  output logic [1:0]                    m_axis_tuser_o
);

  localparam int unsigned EvAw     = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int unsigned Cw       = $clog2(MAX_EVENTS + 1);
  localparam int unsigned TabDepth = SYMBOLS * SYMBOLS * SYMBOLS;
  localparam int unsigned TabAw    = $clog2(TabDepth);
  localparam int unsigned SymW     = tks_pkg::SymW;

  typedef logic [SymW-1:0] sym_t;

  // request fields
  tks_pkg::op_e                   op;
  logic [tks_pkg::IdxW-1:0]       in_index;
  tks_pkg::event_t                in_event;
  logic [tks_pkg::LpW-1:0]        in_logp;
  sym_t                           in_keyval, in_let_a, in_let_b;
  logic                           accept;
  logic [16:0]                    idx17;
  logic [16:0]                    cnt17;
  logic                           swap_ok;
  logic [Cw-1:0]                  n_d;

  assign op                 = tks_pkg::op_e'(s_axis_tuser_i);
  assign in_index           = s_axis_tdata_i[tks_pkg::OffIndex +: tks_pkg::IdxW];
  assign in_event.id_first  = s_axis_tdata_i[tks_pkg::OffFirst +: SymW];
  assign in_event.id_second = s_axis_tdata_i[tks_pkg::OffSecond +: SymW];
  assign in_event.id_third  = s_axis_tdata_i[tks_pkg::OffThird +: SymW];
  assign in_event.weight    = s_axis_tdata_i[tks_pkg::OffWeight +: tks_pkg::WtW];
  assign in_logp            = s_axis_tdata_i[tks_pkg::OffLogP +: tks_pkg::LpW];
  assign in_keyval          = s_axis_tdata_i[tks_pkg::OffKeyVal +: SymW];
  assign in_let_a           = s_axis_tdata_i[tks_pkg::OffLetA +: SymW];
  assign in_let_b           = s_axis_tdata_i[tks_pkg::OffLetB +: SymW];

  // control state
  tks_pkg::state_e          state_q, state_d;
  logic [tks_pkg::CntW-1:0] event_count_q;
  logic [Cw-1:0]            j_q, n_q;
  logic                     swap_q;
  sym_t                     a_q, b_q, map_a_q, map_b_q;
  logic                     v1_q, v2_q, v3_q;

  // fsm outputs
  logic                     issue, key_setup, key_cap, out_load, out_free, pipe_empty;
  logic                     mac_busy;

  assign accept   = s_axis_tvalid_i & s_axis_tready_o;
  assign idx17    = {2'b0, in_index};
  assign cnt17    = {4'b0, event_count_q};
  assign swap_ok  = (in_let_a < SymW'(tks_pkg::Letters)) && (in_let_b < SymW'(tks_pkg::Letters))
                  && (in_let_a != in_let_b);
  assign out_free = ~m_axis_tvalid_o | m_axis_tready_i;
  assign pipe_empty = ~v1_q & ~v2_q & ~v3_q & ~mac_busy;

  always_comb begin
    if (op == tks_pkg::OP_SWAP && !swap_ok) begin
      n_d = '0;
    end else if (cnt17 > 17'(MAX_EVENTS)) begin
      n_d = Cw'(MAX_EVENTS);
    end else begin
      n_d = Cw'(cnt17);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tks_pkg::ST_IDLE: begin
        if (accept && (op inside {tks_pkg::OP_SWAP, tks_pkg::OP_SCORE})) begin
          state_d = tks_pkg::ST_KEY_RD;
        end
      end
      tks_pkg::ST_KEY_RD:  state_d = tks_pkg::ST_KEY_CAP;
      tks_pkg::ST_KEY_CAP: state_d = tks_pkg::ST_SCAN;
      tks_pkg::ST_SCAN: begin
        if (j_q >= n_q && pipe_empty) begin
          state_d = tks_pkg::ST_DONE;
        end
      end
      tks_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tks_pkg::ST_IDLE;
        end
      end
      default: state_d = tks_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    issue           = 1'b0;
    key_setup       = 1'b0;
    key_cap         = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      tks_pkg::ST_IDLE:    s_axis_tready_o = 1'b1;
      tks_pkg::ST_KEY_RD:  key_setup = 1'b1;
      tks_pkg::ST_KEY_CAP: key_cap = 1'b1;
      tks_pkg::ST_SCAN:    issue = (j_q < n_q);
      tks_pkg::ST_DONE:    out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tks_pkg::ST_IDLE;
      event_count_q <= '0;
      j_q           <= '0;
      n_q           <= '0;
      swap_q        <= 1'b0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        event_count_q <= cfg_wdata_i;
      end
      if (accept) begin
        j_q    <= '0;
        n_q    <= n_d;
        swap_q <= (op == tks_pkg::OP_SWAP);
      end else if (issue) begin
        j_q <= j_q + Cw'(1);
      end
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= in_let_a;
      b_q <= in_let_b;
    end
  end

  // event memory
  tks_pkg::event_t ev_mem [MAX_EVENTS];
  tks_pkg::event_t ev_rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && op == tks_pkg::OP_WR_EVENT && idx17 < 17'(MAX_EVENTS)) begin
      ev_mem[idx17[EvAw-1:0]] <= in_event;
    end
    ev_rd_q <= ev_mem[j_q[EvAw-1:0]];
  end

  // stage 1: key lookups, one key copy per symbol slot
  sym_t ids1 [3];
  sym_t key_addr [3];
  sym_t key_mem [3][tks_pkg::Letters];
  sym_t key_rd_q [3];
  sym_t ids2_q [3];
  logic [tks_pkg::WtW-1:0] w2_q, w3_q;

  assign ids1[0] = ev_rd_q.id_first;
  assign ids1[1] = ev_rd_q.id_second;
  assign ids1[2] = ev_rd_q.id_third;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      key_addr[k] = (ids1[k] < SymW'(tks_pkg::Letters)) ? ids1[k] : '0;
    end
    if (key_setup) begin
      key_addr[0] = (a_q < SymW'(tks_pkg::Letters)) ? a_q : '0;
      key_addr[1] = (b_q < SymW'(tks_pkg::Letters)) ? b_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (accept && op == tks_pkg::OP_WR_KEY && in_index < tks_pkg::IdxW'(tks_pkg::Letters)) begin
        key_mem[k][in_index[SymW-1:0]] <= in_keyval;
      end
      key_rd_q[k] <= key_mem[k][key_addr[k]];
      ids2_q[k]   <= ids1[k];
    end
    w2_q <= ev_rd_q.weight;
    w3_q <= w2_q;
    if (key_cap) begin
      map_a_q <= key_rd_q[0];
      map_b_q <= key_rd_q[1];
    end
  end

  // stage 2: mapped symbols, table addresses, table reads
  sym_t                 sym_o [3];
  sym_t                 sym_s [3];
  sym_t                 raw_o;
  sym_t                 raw_s;
  logic [TabAw-1:0]     addr_o, addr_s;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      raw_o = (ids2_q[k] < SymW'(tks_pkg::Letters)) ? key_rd_q[k] : ids2_q[k];
      if (ids2_q[k] == a_q) begin
        raw_s = map_b_q;
      end else if (ids2_q[k] == b_q) begin
        raw_s = map_a_q;
      end else begin
        raw_s = raw_o;
      end
      sym_o[k] = (raw_o > SymW'(SYMBOLS - 1)) ? SymW'(SYMBOLS - 1) : raw_o;
      sym_s[k] = (raw_s > SymW'(SYMBOLS - 1)) ? SymW'(SYMBOLS - 1) : raw_s;
    end
  end

  assign addr_o = (TabAw'(sym_o[0]) * TabAw'(SYMBOLS) + TabAw'(sym_o[1])) * TabAw'(SYMBOLS)
                + TabAw'(sym_o[2]);
  assign addr_s = (TabAw'(sym_s[0]) * TabAw'(SYMBOLS) + TabAw'(sym_s[1])) * TabAw'(SYMBOLS)
                + TabAw'(sym_s[2]);

  logic [tks_pkg::LpW-1:0] tab_mem [TabDepth];
  logic [tks_pkg::LpW-1:0] tab_o_q, tab_s_q;

  always_ff @(posedge clk_i) begin
    if (accept && op == tks_pkg::OP_WR_TABLE && {1'b0, in_index} < 16'(TabDepth)) begin
      tab_mem[in_index[TabAw-1:0]] <= in_logp;
    end
    tab_o_q <= tab_mem[addr_o];
    tab_s_q <= tab_mem[addr_s];
  end

  // stage 3 and 4: multiply and accumulate
  tks_pkg::mac_ctrl_t               mac_ctrl;
  logic signed [tks_pkg::AccW-1:0]  acc;
  logic                             acc_sat;

  assign mac_ctrl.clr  = accept;
  assign mac_ctrl.en   = v3_q;
  assign mac_ctrl.swap = swap_q;

  tks_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .tab_orig_i ($signed(tab_o_q)),
    .tab_swap_i ($signed(tab_s_q)),
    .weight_i   (w3_q),
    .busy_o     (mac_busy),
    .acc_o      (acc),
    .sat_o      (acc_sat)
  );

  // output register
  logic                    m_valid_q;
  logic [tks_pkg::AccW-1:0] out_value_q;
  logic                    out_kind_q, out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= acc;
      out_kind_q  <= ~swap_q;
      out_sat_q   <= acc_sat;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = {out_sat_q, out_kind_q};

endmodule

@@ rtl/tks_mac.sv @@
// ----------------------------------------------------------------------------
// tks_mac
// weighted term multiply and saturating 56-bit accumulate
// ----------------------------------------------------------------------------
module tks_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tks_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [tks_pkg::LpW-1:0]     tab_orig_i,
  input  logic signed [tks_pkg::LpW-1:0]     tab_swap_i,
  input  logic        [tks_pkg::WtW-1:0]     weight_i,
  output logic                               busy_o,
  output logic signed [tks_pkg::AccW-1:0]    acc_o,
  output logic                               sat_o
);

  localparam logic signed [tks_pkg::AccW-1:0] AccMax = {1'b0, {(tks_pkg::AccW-1){1'b1}}};
  localparam logic signed [tks_pkg::AccW-1:0] AccMin = {1'b1, {(tks_pkg::AccW-1){1'b0}}};

  logic signed [tks_pkg::LpW:0]         term;
  logic signed [tks_pkg::WtW:0]         wt_s;
  logic signed [tks_pkg::LpW+tks_pkg::WtW+1:0] prod_full;
  logic signed [tks_pkg::ProdW-1:0]     prod_q;
  logic                                 pv_q;
  logic signed [tks_pkg::AccW:0]        sum;
  logic signed [tks_pkg::AccW-1:0]      acc_q, acc_d;
  logic                                 sat_q, sat_d;

  always_comb begin
    if (ctrl_i.swap) begin
      term = {tab_swap_i[tks_pkg::LpW-1], tab_swap_i} - {tab_orig_i[tks_pkg::LpW-1], tab_orig_i};
    end else begin
      term = {tab_orig_i[tks_pkg::LpW-1], tab_orig_i};
    end
  end

  assign wt_s      = $signed({1'b0, weight_i});
  assign prod_full = term * wt_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[tks_pkg::ProdW-1:0];
  end

  assign sum = {acc_q[tks_pkg::AccW-1], acc_q}
             + {{(tks_pkg::AccW+1-tks_pkg::ProdW){prod_q[tks_pkg::ProdW-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    sat_d = sat_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
      sat_d = 1'b0;
    end else if (pv_q) begin
      if (sum[tks_pkg::AccW] != sum[tks_pkg::AccW-1]) begin
        sat_d = 1'b1;
        acc_d = sum[tks_pkg::AccW] ? AccMin : AccMax;
      end else begin
        acc_d = sum[tks_pkg::AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

  assign busy_o = pv_q;
  assign acc_o  = acc_q;
  assign sat_o  = sat_q;

endmodule
